// ===== sv/strict_utf8_decoder_with_location_macros.svh =====
// Assertion macros for the decoder control module.
// Each macro expects i_clk and i_rst_n in the scope where it is used.
`ifndef STRICT_UTF8_DECODER_WITH_LOCATION_MACROS_SVH
`define STRICT_UTF8_DECODER_WITH_LOCATION_MACROS_SVH
`ifndef SYNTHESIS
`define SUDL_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);
`define SUDL_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define SUDL_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SUDL_ASSERT(lbl, prop, msg)
`define SUDL_ASSERT_IMP(lbl, ante, cons, msg)
`define SUDL_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// ===== sv/sudl_pkg.sv =====
package sudl_pkg;

    localparam int LOC_BITS  = 32;
    localparam int LOC_CNT_W = $clog2(LOC_BITS);
    localparam logic [LOC_BITS-1:0] LOC_MAX = '1;

    // Configuration register indexes
    localparam logic CFG_TAB_WIDTH = 1'b0;
    localparam logic CFG_MODE      = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_OUT,
        S_TAB
    } t_state;

    typedef enum logic [3:0] {
        K_PRINT   = 4'd0,
        K_LF      = 4'd1,
        K_TAB     = 4'd2,
        K_CRLF    = 4'd3,
        K_LONE_CR = 4'd4,
        K_CONTROL = 4'd5,
        K_MULTI   = 4'd6,
        K_INC1    = 4'd7,
        K_INC2    = 4'd8,
        K_INC3    = 4'd9,
        K_SURR    = 4'd10,
        K_BOM     = 4'd11,
        K_END     = 4'd12
    } t_kind;

    // Location step applied after a result is delivered
    typedef enum logic [2:0] {
        ADV_NONE,
        ADV_CHAR,
        ADV_NL1,
        ADV_NL2,
        ADV_TAB
    } t_adv;

    typedef struct packed {
        logic        vld;
        t_kind       kind;
        logic [20:0] cp;
        t_adv        adv;
    } t_emit;

    typedef struct packed {
        logic load;
        logic advance;
        logic tab_start;
        logic tab_apply;
        logic slot;
    } t_cmd;

    typedef struct packed {
        logic slot0_vld;
        logic slot1_vld;
        logic cur_tab;
        logic rem_done;
    } t_status;

endpackage

// ===== sv/sudl_rem.sv =====
module sudl_rem (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [sudl_pkg::LOC_BITS-1:0] i_dividend,
    input  logic [4:0]                   i_divisor,
    output logic                         o_done,
    output logic [4:0]                   o_rem
);

    logic [sudl_pkg::LOC_BITS-1:0]  r_acc;
    logic [4:0]                     r_div;
    logic [4:0]                     r_rem;
    logic [sudl_pkg::LOC_CNT_W-1:0] r_cnt;
    logic                           r_busy;
    logic                           r_done;
    logic [5:0]                     shifted;
    logic [5:0]                     diff;

    // One quotient bit per cycle, most significant first
    assign shifted = {r_rem, r_acc[sudl_pkg::LOC_BITS-1]};
    assign diff    = shifted - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= sudl_pkg::LOC_CNT_W'(sudl_pkg::LOC_BITS - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc <= i_dividend;
            r_div <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_acc <= {r_acc[sudl_pkg::LOC_BITS-2:0], 1'b0};
            r_rem <= (shifted >= {1'b0, r_div}) ? diff[4:0] : shifted[4:0];
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

// ===== sv/sudl_dpath.sv =====
module sudl_dpath (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [7:0]        i_in_byte,
    input  logic              i_end,
    input  logic              i_cfg_we,
    input  logic              i_cfg_index,
    input  logic [4:0]        i_cfg_data,
    input  sudl_pkg::t_cmd    i_cmd,
    output sudl_pkg::t_status o_status,
    output logic [3:0]        o_kind,
    output logic [20:0]       o_cp,
    output logic [31:0]       o_line,
    output logic [31:0]       o_col
);

    localparam int LB  = sudl_pkg::LOC_BITS;
    localparam int LW1 = sudl_pkg::LOC_BITS + 1;

    localparam logic [7:0] B_TAB       = 8'h09;
    localparam logic [7:0] B_LF        = 8'h0a;
    localparam logic [7:0] B_CR        = 8'h0d;
    localparam logic [7:0] B_SPACE     = 8'h20;
    localparam logic [7:0] B_TILDE     = 8'h7e;
    localparam logic [7:0] B_DEL       = 8'h7f;
    localparam logic [7:0] B_CONT_LO   = 8'h80;
    localparam logic [7:0] B_CONT_HI   = 8'hbf;
    localparam logic [7:0] B_E0_LO     = 8'ha0;
    localparam logic [7:0] B_F0_LO     = 8'h90;
    localparam logic [7:0] B_F4_HI     = 8'h8f;
    localparam logic [7:0] B_LEAD_MIN  = 8'hc2;
    localparam logic [7:0] B_LEAD_3    = 8'he0;
    localparam logic [7:0] B_LEAD_4    = 8'hf0;
    localparam logic [7:0] B_LEAD_MAX  = 8'hf4;
    localparam logic [20:0] CP_SURR_LO = 21'h00d800;
    localparam logic [20:0] CP_SURR_HI = 21'h00dfff;
    localparam logic [20:0] CP_BOM     = 21'h00feff;

    function automatic sudl_pkg::t_emit no_emit();
        sudl_pkg::t_emit e;
        e.vld  = 1'b0;
        e.kind = sudl_pkg::K_PRINT;
        e.cp   = '0;
        e.adv  = sudl_pkg::ADV_NONE;
        return e;
    endfunction

    function automatic sudl_pkg::t_emit mk_emit(input sudl_pkg::t_kind k,
                                                input logic [20:0] cp,
                                                input sudl_pkg::t_adv a);
        sudl_pkg::t_emit e;
        e.vld  = 1'b1;
        e.kind = k;
        e.cp   = cp;
        e.adv  = a;
        return e;
    endfunction

    function automatic sudl_pkg::t_emit fresh_emit(input logic [7:0] b);
        sudl_pkg::t_emit e;
        e = mk_emit(sudl_pkg::K_PRINT, {13'd0, b}, sudl_pkg::ADV_CHAR);
        if (b >= B_SPACE && b <= B_TILDE) begin
            e.kind = sudl_pkg::K_PRINT;
        end else if (b == B_LF) begin
            e.kind = sudl_pkg::K_LF;
            e.adv  = sudl_pkg::ADV_NL1;
        end else if (b == B_TAB) begin
            e.kind = sudl_pkg::K_TAB;
            e.adv  = sudl_pkg::ADV_TAB;
        end else if (b == B_CR) begin
            e = no_emit();
        end else if (b < B_SPACE || b == B_DEL) begin
            e.kind = sudl_pkg::K_CONTROL;
        end else if (b >= B_LEAD_MIN && b <= B_LEAD_MAX) begin
            e = no_emit();
        end else begin
            e.kind = sudl_pkg::K_INC1;
            e.cp   = '0;
        end
        return e;
    endfunction

    function automatic sudl_pkg::t_kind inc_kind(input logic [1:0] taken);
        sudl_pkg::t_kind k;
        case (taken)
            2'd1:    k = sudl_pkg::K_INC1;
            2'd2:    k = sudl_pkg::K_INC2;
            default: k = sudl_pkg::K_INC3;
        endcase
        return k;
    endfunction

    function automatic logic [LB-1:0] sat_add(input logic [LB-1:0] x, input logic [1:0] k);
        logic [LB:0] sum;
        sum = {1'b0, x} + LW1'(k);
        return sum[LB] ? sudl_pkg::LOC_MAX : sum[LB-1:0];
    endfunction

    logic [4:0]      r_tab_width;
    logic            r_mode;
    logic [7:0]      r_lead,    n_lead;
    logic [1:0]      r_taken,   n_taken;
    logic [20:0]     r_partial, n_partial;
    logic            r_cr,      n_cr;
    logic [LB-1:0]   r_line;
    logic [LB-1:0]   r_col;
    sudl_pkg::t_emit r_emit0,   r_emit1;

    sudl_pkg::t_emit pre_e, main_e, cur;
    logic            fr_cr, fr_lead;
    logic [20:0]     fr_partial;
    logic [7:0]      lo, hi;
    logic [1:0]      new_taken, total;
    logic [20:0]     new_partial;

    logic [4:0]      tw_eff;
    logic [LB-1:0]   col_m1, tab_base;
    logic [LB:0]     tab_sum;
    logic [LB-1:0]   tab_col;
    logic            rem_done;
    logic [4:0]      rem;
    logic [63:0]     line64, col64;

    // Effect of a byte decoded from scratch on the decode state
    always_comb begin
        fr_cr   = (i_in_byte == B_CR);
        fr_lead = (i_in_byte >= B_LEAD_MIN) && (i_in_byte <= B_LEAD_MAX);
        if (i_in_byte < B_LEAD_3) begin
            fr_partial = {16'd0, i_in_byte[4:0]};
        end else if (i_in_byte < B_LEAD_4) begin
            fr_partial = {17'd0, i_in_byte[3:0]};
        end else begin
            fr_partial = {18'd0, i_in_byte[2:0]};
        end
    end

    always_comb begin
        lo = B_CONT_LO;
        hi = B_CONT_HI;
        if (r_taken == 2'd1) begin
            if (r_lead == B_LEAD_3) begin
                lo = B_E0_LO;
            end else if (r_lead == B_LEAD_4) begin
                lo = B_F0_LO;
            end else if (r_lead == B_LEAD_MAX) begin
                hi = B_F4_HI;
            end
        end
        new_partial = {r_partial[14:0], i_in_byte[5:0]};
        new_taken   = r_taken + 2'd1;
        // A four-byte sequence completes when the 2-bit count wraps to zero
        if (r_lead < B_LEAD_3) begin
            total = 2'd2;
        end else if (r_lead < B_LEAD_4) begin
            total = 2'd3;
        end else begin
            total = 2'd0;
        end
    end

    // Plan up to two results for the incoming beat
    always_comb begin
        n_lead    = r_lead;
        n_taken   = r_taken;
        n_partial = r_partial;
        n_cr      = r_cr;
        pre_e     = no_emit();
        main_e    = no_emit();
        if (i_end) begin
            if (r_cr) begin
                pre_e = mk_emit(sudl_pkg::K_LONE_CR, {13'd0, B_CR}, sudl_pkg::ADV_NL1);
            end else if (r_taken != 2'd0) begin
                pre_e = mk_emit(inc_kind(r_taken), '0, sudl_pkg::ADV_CHAR);
            end
            main_e    = mk_emit(sudl_pkg::K_END, '0, sudl_pkg::ADV_NONE);
            n_cr      = 1'b0;
            n_taken   = '0;
            n_lead    = '0;
            n_partial = '0;
        end else if (r_cr || (r_taken != 2'd0 && (i_in_byte < lo || i_in_byte > hi))) begin
            if (r_cr && i_in_byte == B_LF) begin
                pre_e = mk_emit(sudl_pkg::K_CRLF, '0, sudl_pkg::ADV_NL2);
                n_cr  = 1'b0;
            end else begin
                if (r_cr) begin
                    pre_e = mk_emit(sudl_pkg::K_LONE_CR, {13'd0, B_CR}, sudl_pkg::ADV_NL1);
                end else begin
                    pre_e = mk_emit(inc_kind(r_taken), '0, sudl_pkg::ADV_CHAR);
                end
                main_e    = fresh_emit(i_in_byte);
                n_cr      = fr_cr;
                n_taken   = fr_lead ? 2'd1 : 2'd0;
                n_lead    = fr_lead ? i_in_byte : 8'd0;
                n_partial = fr_lead ? fr_partial : 21'd0;
            end
        end else if (r_taken != 2'd0) begin
            if (new_taken == total) begin
                if (total == 2'd3 && new_partial >= CP_SURR_LO &&
                    new_partial <= CP_SURR_HI) begin
                    main_e = mk_emit(sudl_pkg::K_SURR, '0, sudl_pkg::ADV_CHAR);
                end else if (total == 2'd3 && new_partial == CP_BOM) begin
                    main_e = mk_emit(sudl_pkg::K_BOM, '0, sudl_pkg::ADV_CHAR);
                end else begin
                    main_e = mk_emit(sudl_pkg::K_MULTI, new_partial, sudl_pkg::ADV_CHAR);
                end
                n_taken   = '0;
                n_lead    = '0;
                n_partial = '0;
            end else begin
                n_taken   = new_taken;
                n_partial = new_partial;
            end
        end else begin
            main_e    = fresh_emit(i_in_byte);
            n_cr      = fr_cr;
            n_taken   = fr_lead ? 2'd1 : 2'd0;
            n_lead    = fr_lead ? i_in_byte : 8'd0;
            n_partial = fr_lead ? fr_partial : 21'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lead    <= '0;
            r_taken   <= '0;
            r_partial <= '0;
            r_cr      <= 1'b0;
            r_emit0   <= no_emit();
            r_emit1   <= no_emit();
        end else if (i_cmd.load) begin
            r_lead    <= n_lead;
            r_taken   <= n_taken;
            r_partial <= n_partial;
            r_cr      <= n_cr;
            // Pack so that slot 0 always holds the first result
            r_emit0   <= pre_e.vld ? pre_e : main_e;
            r_emit1   <= pre_e.vld ? main_e : no_emit();
        end
    end

    assign cur = i_cmd.slot ? r_emit1 : r_emit0;

    assign tw_eff   = (r_tab_width == 5'd0) ? 5'd1 : r_tab_width;
    assign col_m1   = (r_col == '0) ? '0 : r_col - 1'b1;
    assign tab_base = col_m1 - LB'(rem);
    assign tab_sum  = {1'b0, tab_base} + LW1'(1) + LW1'(tw_eff);
    assign tab_col  = tab_sum[LB] ? sudl_pkg::LOC_MAX : tab_sum[LB-1:0];

    sudl_rem u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.tab_start),
        .i_dividend (col_m1),
        .i_divisor  (tw_eff),
        .o_done     (rem_done),
        .o_rem      (rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tab_width <= 5'd4;
            r_mode      <= 1'b0;
            r_line      <= LB'(1);
            r_col       <= LB'(1);
        end else begin
            if (i_cmd.advance) begin
                case (cur.adv)
                    sudl_pkg::ADV_CHAR,
                    sudl_pkg::ADV_TAB: begin
                        r_col <= sat_add(r_col, 2'd1);
                    end
                    sudl_pkg::ADV_NL1,
                    sudl_pkg::ADV_NL2: begin
                        if (r_mode) begin
                            r_col <= sat_add(r_col, (cur.adv == sudl_pkg::ADV_NL2) ? 2'd2 : 2'd1);
                        end else begin
                            r_line <= sat_add(r_line, 2'd1);
                            r_col  <= LB'(1);
                        end
                    end
                    default: begin
                    end
                endcase
            end
            if (i_cmd.tab_apply) begin
                r_col <= tab_col;
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    sudl_pkg::CFG_TAB_WIDTH: begin
                        r_tab_width <= i_cfg_data;
                    end
                    sudl_pkg::CFG_MODE: begin
                        r_mode <= i_cfg_data[0];
                        r_line <= i_cfg_data[0] ? LB'(0) : LB'(1);
                        r_col  <= LB'(1);
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    assign o_status.slot0_vld = r_emit0.vld;
    assign o_status.slot1_vld = r_emit1.vld;
    assign o_status.cur_tab   = (cur.adv == sudl_pkg::ADV_TAB) && !r_mode;
    assign o_status.rem_done  = rem_done;

    assign line64 = 64'(r_line);
    assign col64  = 64'(r_col);
    assign o_kind = cur.kind;
    assign o_cp   = cur.cp;
    assign o_line = r_mode ? 32'd0 : line64[31:0];
    assign o_col  = col64[31:0];

endmodule

// ===== sv/sudl_ctrl.sv =====
`include "strict_utf8_decoder_with_location_macros.svh"

module sudl_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic              o_out_last,
    output sudl_pkg::t_cmd    o_cmd,
    input  sudl_pkg::t_status i_status
);

    sudl_pkg::t_state r_state, n_state;
    logic             r_slot,  n_slot;
    logic             more;

    // Another result follows the one in slot 0
    assign more = !r_slot && i_status.slot1_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sudl_pkg::S_IDLE;
            r_slot  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_slot  <= n_slot;
        end
    end

    always_comb begin
        n_state = r_state;
        n_slot  = r_slot;
        case (r_state)
            sudl_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = sudl_pkg::S_CHECK;
                    n_slot  = 1'b0;
                end
            end
            sudl_pkg::S_CHECK: begin
                n_state = i_status.slot0_vld ? sudl_pkg::S_OUT : sudl_pkg::S_IDLE;
            end
            sudl_pkg::S_OUT: begin
                if (i_out_ready) begin
                    if (i_status.cur_tab) begin
                        n_state = sudl_pkg::S_TAB;
                    end else if (more) begin
                        n_slot = 1'b1;
                    end else begin
                        n_state = sudl_pkg::S_IDLE;
                    end
                end
            end
            sudl_pkg::S_TAB: begin
                if (i_status.rem_done) begin
                    if (more) begin
                        n_slot  = 1'b1;
                        n_state = sudl_pkg::S_OUT;
                    end else begin
                        n_state = sudl_pkg::S_IDLE;
                    end
                end
            end
            default: begin
                n_state = sudl_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready      = (r_state == sudl_pkg::S_IDLE);
        o_out_valid     = (r_state == sudl_pkg::S_OUT);
        o_out_last      = !more;
        o_cmd.load      = (r_state == sudl_pkg::S_IDLE) && i_in_valid;
        o_cmd.advance   = (r_state == sudl_pkg::S_OUT) && i_out_ready && !i_status.cur_tab;
        o_cmd.tab_start = (r_state == sudl_pkg::S_OUT) && i_out_ready && i_status.cur_tab;
        o_cmd.tab_apply = (r_state == sudl_pkg::S_TAB) && i_status.rem_done;
        o_cmd.slot      = r_slot;
    end

    `SUDL_ASSERT(a_one_at_a_time, !(o_in_ready && o_out_valid), "input taken while result pending")
    `SUDL_ASSERT_IMP(a_rem_in_tab, i_status.rem_done, r_state == sudl_pkg::S_TAB, "stray tab done")
    `SUDL_ASSERT_IMP(a_slot1_valid, o_out_valid && r_slot, i_status.slot1_vld, "empty second slot")
    `SUDL_ASSERT_NXT(a_load_check, o_cmd.load, r_state == sudl_pkg::S_CHECK, "load not followed by check")

endmodule

// ===== sv/strict_utf8_decoder_with_location.sv =====
// Strict UTF-8 decoder with line/column tracking.
// Input stream: one beat per source byte on s_axis; tuser set marks end of
// input (tdata ignored), which flushes a pending sequence or CR and yields
// an end result. Output stream: zero, one or two results per input beat on
// m_axis, tlast set on the final result caused by that beat.
// Configuration: i_cfg_we writes tab width (index 0) or location mode
// (index 1) in the same cycle; write only while the block is idle.
// Sequencing: one input beat is handled at a time. A beat with no result is
// loaded and checked, then the block is idle again; each result is held until
// m_axis_tready is high. A tab in line mode also waits for the bit-serial
// remainder unit that finds the current tab stop.
// Reset: decode state clears, tab width 4, line mode, location line 1
// column 1. A stalled receiver holds the current result and the location
// frozen; no new input beat is taken until all its results are delivered.
module strict_utf8_decoder_with_location (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // in_byte
    input  logic        s_axis_tuser,   // end_of_input
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [95:0] m_axis_tdata,   // char_kind, code_point, start_line, start_column, zeros
    output logic        m_axis_tlast,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [4:0]  i_cfg_data
);

    sudl_pkg::t_cmd    cmd;
    sudl_pkg::t_status status;
    logic [3:0]        kind;
    logic [20:0]       cp;
    logic [31:0]       line;
    logic [31:0]       col;

    sudl_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_last  (m_axis_tlast),
        .o_cmd       (cmd),
        .i_status    (status)
    );

    sudl_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_byte   (s_axis_tdata),
        .i_end       (s_axis_tuser),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_kind      (kind),
        .o_cp        (cp),
        .o_line      (line),
        .o_col       (col)
    );

    assign m_axis_tdata = {7'd0, col, line, cp, kind};

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps

module tb;

    localparam logic [8:0] END_BEAT      = 9'h1ff;
    localparam logic [63:0] LOC_TOP      = (64'd1 << sudl_pkg::LOC_BITS) - 64'd1;
    // worst case: line-mode tab walk plus handoff
    localparam int SETTLE_CYCLES = 60;

    typedef struct {
        sudl_pkg::t_kind kind;
        logic [20:0]     cp;
        logic [31:0]     line;
        logic [31:0]     col;
        logic            last;
    } t_char;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'd0;
    logic        s_axis_tuser  = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [95:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic        i_cfg_we      = 1'b0;
    logic        i_cfg_index   = 1'b0;
    logic [4:0]  i_cfg_data    = 5'd0;

    // bit 8 marks end of input, bits 7:0 carry the byte
    logic [8:0] byte_q [$];
    t_char      char_q [$];
    logic [8:0] beat;
    int         send_gap   = 0;
    int         recv_gap   = 0;
    int         fail_count = 0;
    bit         gaps_on    = 1'b1;

    // decoder state as seen by the predictor
    logic [4:0]  tab_w     = 5'd4;
    logic        loc_mode  = 1'b0;
    logic [7:0]  lead_b    = 8'd0;
    logic [1:0]  seq_taken = 2'd0;
    logic [20:0] seq_value = 21'd0;
    logic        cr_held   = 1'b0;
    logic [63:0] line_no   = 64'd1;
    logic [63:0] col_no    = 64'd1;

    logic [8:0] opening [27] = '{
        9'h020, 9'h07e, 9'h000, 9'h07f, 9'h009, 9'h00a, 9'h00d, 9'h00a,
        9'h0ed, 9'h0a0, 9'h080, 9'h0ef, 9'h0bb, 9'h0bf,
        9'h0f4, 9'h08f, 9'h0bf, 9'h0bf, 9'h0ff, 9'h0e0, 9'h09f,
        9'h0e1, 9'h080, END_BEAT, 9'h00d, 9'h00d, END_BEAT
    };
    logic [4:0] tab_plan  [8] = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd7, 5'd3, 5'd9, 5'd4};
    logic       mode_plan [8] = '{1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1};

    strict_utf8_decoder_with_location dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // in_byte
        .s_axis_tuser  (s_axis_tuser),   // end_of_input
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // char_kind, code_point, start_line, start_column
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    // ---------------- predictor ----------------

    function automatic logic [63:0] sat_add(logic [63:0] x, logic [63:0] k);
        if (x > LOC_TOP || LOC_TOP - x < k)
            return LOC_TOP;
        return x + k;
    endfunction

    task automatic note_char(sudl_pkg::t_kind kind, logic [20:0] cp);
        t_char entry;
        entry.kind = kind;
        entry.cp   = cp;
        entry.line = loc_mode ? 32'd0 : line_no[31:0];
        entry.col  = col_no[31:0];
        entry.last = 1'b0;
        char_q.insert(char_q.size(), entry);
    endtask

    task automatic step_char();
        col_no = sat_add(col_no, 64'd1);
    endtask

    task automatic step_newline(logic [63:0] index_step);
        if (loc_mode) begin
            col_no = sat_add(col_no, index_step);
        end else begin
            line_no = sat_add(line_no, 64'd1);
            col_no  = 64'd1;
        end
    endtask

    task automatic step_tab();
        logic [63:0] tw;
        logic [63:0] c;
        logic [63:0] base;
        if (loc_mode) begin
            step_char();
            return;
        end
        tw = (tab_w == 5'd0) ? 64'd1 : {59'd0, tab_w};
        c = (col_no != 64'd0) ? col_no - 64'd1 : 64'd0;
        base = c - (c % tw);
        col_no = sat_add(base + 64'd1, tw);
    endtask

    task automatic clear_seq();
        seq_taken = 2'd0;
        lead_b    = 8'd0;
        seq_value = 21'd0;
    endtask

    task automatic start_char(logic [7:0] b);
        if (b >= 8'h20 && b <= 8'h7e) begin
            note_char(sudl_pkg::K_PRINT, {13'd0, b});
            step_char();
        end else if (b == 8'h0a) begin
            note_char(sudl_pkg::K_LF, {13'd0, b});
            step_newline(64'd1);
        end else if (b == 8'h09) begin
            note_char(sudl_pkg::K_TAB, {13'd0, b});
            step_tab();
        end else if (b == 8'h0d) begin
            cr_held = 1'b1;
        end else if (b < 8'h20 || b == 8'h7f) begin
            note_char(sudl_pkg::K_CONTROL, {13'd0, b});
            step_char();
        end else if (b >= 8'hc2 && b <= 8'hf4) begin
            lead_b    = b;
            seq_taken = 2'd1;
            seq_value = (b < 8'he0) ? 21'(b & 8'h1f) :
                        (b < 8'hf0) ? 21'(b & 8'h0f) : 21'(b & 8'h07);
        end else begin
            note_char(sudl_pkg::K_INC1, 21'd0);
            step_char();
        end
    endtask

    task automatic extend_seq(logic [7:0] b);
        logic [7:0] lo;
        logic [7:0] hi;
        int         total;
        int         got;
        lo = 8'h80;
        hi = 8'hbf;
        if (seq_taken == 2'd1) begin
            if (lead_b == 8'he0)
                lo = 8'ha0;
            else if (lead_b == 8'hf0)
                lo = 8'h90;
            else if (lead_b == 8'hf4)
                hi = 8'h8f;
        end
        if (b < lo || b > hi) begin
            // cut short: report it, then take the byte as a new start
            note_char(sudl_pkg::t_kind'(sudl_pkg::K_MULTI + seq_taken), 21'd0);
            step_char();
            clear_seq();
            start_char(b);
            return;
        end
        seq_value = {seq_value[14:0], b[5:0]};
        seq_taken = seq_taken + 2'd1;
        total = (lead_b < 8'he0) ? 2 : (lead_b < 8'hf0) ? 3 : 4;
        got = (seq_taken == 2'd0) ? 4 : int'(seq_taken);
        if (got != total)
            return;
        if (total == 3 && seq_value >= 21'h00d800 && seq_value <= 21'h00dfff)
            note_char(sudl_pkg::K_SURR, 21'd0);
        else if (total == 3 && seq_value == 21'h00feff)
            note_char(sudl_pkg::K_BOM, 21'd0);
        else
            note_char(sudl_pkg::K_MULTI, seq_value);
        step_char();
        clear_seq();
    endtask

    task automatic decode_beat(logic [7:0] b, logic eoi);
        int first;
        first = char_q.size();
        if (eoi) begin
            if (cr_held) begin
                note_char(sudl_pkg::K_LONE_CR, 21'h0d);
                step_newline(64'd1);
            end else if (seq_taken != 2'd0) begin
                note_char(sudl_pkg::t_kind'(sudl_pkg::K_MULTI + seq_taken), 21'd0);
                step_char();
            end
            cr_held = 1'b0;
            clear_seq();
            note_char(sudl_pkg::K_END, 21'd0);
        end else if (cr_held) begin
            cr_held = 1'b0;
            if (b == 8'h0a) begin
                note_char(sudl_pkg::K_CRLF, 21'd0);
                step_newline(64'd2);
            end else begin
                note_char(sudl_pkg::K_LONE_CR, 21'h0d);
                step_newline(64'd1);
                start_char(b);
            end
        end else if (seq_taken != 2'd0) begin
            extend_seq(b);
        end else begin
            start_char(b);
        end
        if (char_q.size() > first)
            char_q[char_q.size() - 1].last = 1'b1;
    endtask

    // ---------------- stimulus helpers ----------------

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic void push_beat(logic [7:0] b, logic eoi);
        logic [8:0] entry;
        entry = {eoi, b};
        byte_q.insert(byte_q.size(), entry);
    endfunction

    // Queue one multibyte character, or a prefix of one and a stray byte
    function automatic int push_seq(int nbytes, bit broken);
        logic [7:0] seq [4];
        int keep;
        case (nbytes)
            2:       seq[0] = 8'($urandom_range(8'hc2, 8'hdf));
            3:       seq[0] = 8'($urandom_range(8'he0, 8'hef));
            default: seq[0] = 8'($urandom_range(8'hf0, 8'hf4));
        endcase
        for (int k = 1; k < 4; k++)
            seq[k] = 8'($urandom_range(8'h80, 8'hbf));
        if (seq[0] == 8'he0)
            seq[1] = 8'($urandom_range(8'ha0, 8'hbf));
        else if (seq[0] == 8'hf0)
            seq[1] = 8'($urandom_range(8'h90, 8'hbf));
        else if (seq[0] == 8'hf4)
            seq[1] = 8'($urandom_range(8'h80, 8'h8f));
        if (nbytes == 3 && $urandom_range(0, 5) == 0) begin
            seq[0] = 8'hed;
            seq[1] = 8'($urandom_range(8'ha0, 8'hbf));
        end else if (nbytes == 3 && $urandom_range(0, 7) == 0) begin
            seq[0] = 8'hef;
            seq[1] = 8'hbb;
            seq[2] = 8'hbf;
        end
        keep = broken ? $urandom_range(1, nbytes - 1) : nbytes;
        for (int k = 0; k < keep; k++)
            push_beat(seq[k], 1'b0);
        if (!broken)
            return keep;
        if ($urandom_range(0, 4) == 0)
            push_beat(8'($urandom), 1'b1);
        else
            push_beat(8'($urandom), 1'b0);
        return keep + 1;
    endfunction

    task automatic fill_random(int count);
        int made;
        int r;
        made = 0;
        while (made < count) begin
            r = $urandom_range(0, 99);
            if (r < 24) begin
                push_beat(8'($urandom_range(8'h20, 8'h7e)), 1'b0);
                made++;
            end else if (r < 31) begin
                if ($urandom_range(0, 32) == 32)
                    push_beat(8'h7f, 1'b0);
                else
                    push_beat(8'($urandom_range(0, 31)), 1'b0);
                made++;
            end else if (r < 39) begin
                push_beat(8'h09, 1'b0);
                made++;
            end else if (r < 45) begin
                push_beat(8'h0a, 1'b0);
                made++;
            end else if (r < 52) begin
                push_beat(8'h0d, 1'b0);
                made++;
                if ($urandom_range(0, 1) == 1) begin
                    push_beat(8'h0a, 1'b0);
                    made++;
                end
            end else if (r < 78) begin
                made += push_seq($urandom_range(2, 4), 1'b0);
            end else if (r < 89) begin
                made += push_seq($urandom_range(2, 4), 1'b1);
            end else if (r < 97) begin
                push_beat(8'($urandom), 1'b0);
                made++;
            end else begin
                push_beat(8'($urandom), 1'b1);
                made++;
            end
        end
    endtask

    // Hold until every queued byte is taken and every character has come back
    task automatic drain();
        do
            @(posedge i_clk);
        while (byte_q.size() != 0 || s_axis_tvalid || char_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [4:0] value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        if (idx == sudl_pkg::CFG_TAB_WIDTH) begin
            tab_w = value;
        end else begin
            loc_mode = value[0];
            line_no  = value[0] ? 64'd0 : 64'd1;
            col_no   = 64'd1;
        end
    endtask

    // ---------------- driver ----------------

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                decode_beat(s_axis_tdata, s_axis_tuser);
            if (!s_axis_tvalid || s_axis_tready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_axis_tvalid <= 1'b0;
                end else if (byte_q.size() != 0) begin
                    beat = byte_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= beat[7:0];
                    s_axis_tuser  <= beat[8];
                    if (gaps_on)
                        send_gap = gap_len();
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // ---------------- monitor ----------------

    task automatic cmp_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            fail_count++;
        end
    endtask

    task automatic check_char();
        t_char want;
        if (char_q.size() == 0) begin
            $display("%0t: unexpected result, expected none, got tdata=%h tlast=%b",
                     $time, m_axis_tdata, m_axis_tlast);
            fail_count++;
            return;
        end
        want = char_q.pop_front();
        cmp_field("char_kind", 32'(want.kind), 32'(m_axis_tdata[3:0]));
        cmp_field("code_point", 32'(want.cp), 32'(m_axis_tdata[24:4]));
        cmp_field("start_line", want.line, m_axis_tdata[56:25]);
        cmp_field("start_column", want.col, m_axis_tdata[88:57]);
        cmp_field("last_of_run", 32'(want.last), 32'(m_axis_tlast));
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready)
                check_char();
            if (recv_gap > 0) begin
                recv_gap--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                if (gaps_on)
                    recv_gap = gap_len();
            end
        end
    end

    // ---------------- sequence ----------------

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: tab width 4, line mode
        foreach (opening[k])
            push_beat(opening[k][7:0], opening[k][8]);
        drain();

        for (int p = 0; p < 8; p++) begin
            write_reg(sudl_pkg::CFG_TAB_WIDTH,
                      (p == 7) ? 5'($urandom_range(0, 31)) : tab_plan[p]);
            write_reg(sudl_pkg::CFG_MODE, {4'd0, mode_plan[p]});
            gaps_on = (p % 3 != 2);
            fill_random(175);
            drain();
        end

        if (fail_count == 0)
            $display("strict_utf8_decoder_with_location verification clean");
        else
            $display("strict_utf8_decoder_with_location verification failed");
        $finish;
    end

    initial begin
        #15_000_000;
        $display("strict_utf8_decoder_with_location verification failed");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+sv
sv/sudl_pkg.sv
sv/sudl_rem.sv
sv/sudl_dpath.sv
sv/sudl_ctrl.sv
sv/strict_utf8_decoder_with_location.sv
verif/tb.sv
